>>> rtl/hdmc_pkg.sv
`timescale 1ns / 1ps

package hdmc_pkg;

   // Field widths
   localparam int KEY_W          = 64;
   localparam int BYTE_W         = 8;
   localparam int RTYPE_W        = 16;
   localparam int RCLASS_W       = 16;
   localparam int HANDLE_W       = 32;
   localparam int TIME_W         = 32;
   localparam int COUNT_W        = 32;
   localparam int SLOT_INDEX_W   = 10;

   // Slot table geometry: the index is the low hash bits
   localparam int SLOT_IDX_W     = 10;
   localparam int SLOT_COUNT     = 1 << SLOT_IDX_W;

   // FNV-1a 64: the prime is 2^40 + 0x1b3, so the multiply is a shift plus
   // a narrow constant product
   localparam logic [KEY_W-1:0] FNV_BASIS       = 64'hCBF29CE484222325;
   localparam int               FNV_PRIME_SHIFT = 40;
   localparam logic [8:0]       FNV_PRIME_LOW   = 9'h1B3;

   // Record type goes into the key shifted by this amount
   localparam int TYPE_SHIFT     = 16;

   // Depth of the queue between front and back
   localparam int Q_DEPTH        = 2;
   localparam int Q_PTR_W        = $clog2(Q_DEPTH);
   localparam int Q_CNT_W        = $clog2(Q_DEPTH + 1);

   typedef enum logic [1:0] {
      ACT_BYTE   = 2'd0,
      ACT_LOOKUP = 2'd1,
      ACT_INSERT = 2'd2
   } action_type;

   // One finished key on its way to the table
   typedef struct packed {
      logic                is_insert;
      logic [KEY_W-1:0]    key;
      logic [HANDLE_W-1:0] handle;
      logic [TIME_W-1:0]   expiry;
      logic [TIME_W-1:0]   now;
   } job_type;

   // Queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // One table slot as stored in the RAM word
   typedef struct packed {
      logic                valid;
      logic [KEY_W-1:0]    key_hash;
      logic [HANDLE_W-1:0] handle;
      logic [TIME_W-1:0]   expiry;
      logic [COUNT_W-1:0]  hits;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

   // One FNV-1a round: xor the byte in, multiply by the prime mod 2^64
   function automatic logic [KEY_W-1:0] fnv_step(logic [KEY_W-1:0] h, logic [BYTE_W-1:0] b);
      logic [KEY_W-1:0] x;
      x = h ^ {{(KEY_W-BYTE_W){1'b0}}, b};
      return (x << FNV_PRIME_SHIFT) + (x * KEY_W'(FNV_PRIME_LOW));
   endfunction

   // Key with record type and class folded in
   function automatic logic [KEY_W-1:0] finish_key(logic [KEY_W-1:0] h,
                                                   logic [RTYPE_W-1:0] rtype,
                                                   logic [RCLASS_W-1:0] rclass);
      return h ^ (KEY_W'(rtype) << TYPE_SHIFT) ^ KEY_W'(rclass);
   endfunction

   // Slot index as reported on the result channel
   function automatic logic [SLOT_INDEX_W-1:0] slot_index_of(logic [KEY_W-1:0] key);
      return SLOT_INDEX_W'(key[SLOT_IDX_W-1:0]);
   endfunction

endpackage

>>> rtl/hdmc_ram.sv
`timescale 1ns / 1ps

module hdmc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/hdmc_front.sv
`timescale 1ns / 1ps

module hdmc_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_action,
   input  logic [hdmc_pkg::BYTE_W-1:0]        req_name_byte,
   input  logic [hdmc_pkg::RTYPE_W-1:0]       req_record_type,
   input  logic [hdmc_pkg::RCLASS_W-1:0]      req_record_class,
   input  logic [hdmc_pkg::HANDLE_W-1:0]      req_entry_handle,
   input  logic [hdmc_pkg::TIME_W-1:0]        req_expiry_time,
   input  logic [hdmc_pkg::TIME_W-1:0]        req_now_time,
   input  hdmc_pkg::q_status_type             q_status,
   input  logic                               clearing,
   output logic                               push,
   output hdmc_pkg::job_type                  push_job
);

   logic [hdmc_pkg::KEY_W-1:0] hash_ff;
   logic [hdmc_pkg::KEY_W-1:0] hash_in;
   logic                       accept;

   // Hold off while the table is being cleared or the queue is full
   assign req_stall = clearing | q_status.full;
   assign accept    = req_valid & ~req_stall;

   // Classify the beat: fold a name byte, or finish the key and hand it on
   always_comb begin
      hash_in            = hash_ff;
      push               = 1'b0;
      push_job.is_insert = (hdmc_pkg::action_type'(req_action) == hdmc_pkg::ACT_INSERT);
      push_job.key       = hdmc_pkg::finish_key(hash_ff, req_record_type, req_record_class);
      push_job.handle    = req_entry_handle;
      push_job.expiry    = req_expiry_time;
      push_job.now       = req_now_time;
      if (accept) begin
         unique case (hdmc_pkg::action_type'(req_action))
            hdmc_pkg::ACT_BYTE: begin
               hash_in = hdmc_pkg::fnv_step(hash_ff, req_name_byte);
            end
            hdmc_pkg::ACT_LOOKUP, hdmc_pkg::ACT_INSERT: begin
               push    = 1'b1;
               hash_in = hdmc_pkg::FNV_BASIS;
            end
            default: begin
               // unused action code: dropped
            end
         endcase
      end
   end

   // Running hash
   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= hdmc_pkg::FNV_BASIS;
      end else begin
         hash_ff <= hash_in;
      end
   end

endmodule

>>> rtl/hdmc_queue.sv
`timescale 1ns / 1ps

module hdmc_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  hdmc_pkg::job_type      push_job,
   input  logic                   pop,
   output hdmc_pkg::job_type      head,
   output hdmc_pkg::q_status_type status
);

   hdmc_pkg::job_type                 slots_ff [hdmc_pkg::Q_DEPTH];
   logic [hdmc_pkg::Q_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [hdmc_pkg::Q_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [hdmc_pkg::Q_CNT_W-1:0]      cnt_ff, cnt_in;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == hdmc_pkg::Q_PTR_W'(hdmc_pkg::Q_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == hdmc_pkg::Q_PTR_W'(hdmc_pkg::Q_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      cnt_in = cnt_ff + hdmc_pkg::Q_CNT_W'(push) - hdmc_pkg::Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head         = slots_ff[rd_ptr_ff];
   assign status.full  = (cnt_ff == hdmc_pkg::Q_CNT_W'(hdmc_pkg::Q_DEPTH));
   assign status.empty = (cnt_ff == '0);

endmodule

>>> rtl/hdmc_back.sv
`timescale 1ns / 1ps

module hdmc_back (
   input  logic                                clock,
   input  logic                                reset,
   input  hdmc_pkg::job_type                   head,
   input  hdmc_pkg::q_status_type              q_status,
   output logic                                pop,
   output logic                                clearing,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_hit,
   output logic [hdmc_pkg::HANDLE_W-1:0]       rsp_handle_out,
   output logic [hdmc_pkg::COUNT_W-1:0]        rsp_hit_count,
   output logic [hdmc_pkg::KEY_W-1:0]          rsp_key_hash,
   output logic [hdmc_pkg::SLOT_INDEX_W-1:0]   rsp_slot_index
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type                              state_ff, state_in;
   logic [hdmc_pkg::SLOT_IDX_W-1:0]        clr_ff, clr_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic                                   rsp_hit_ff, rsp_hit_in;
   logic [hdmc_pkg::HANDLE_W-1:0]          rsp_handle_ff, rsp_handle_in;
   logic [hdmc_pkg::COUNT_W-1:0]           rsp_count_ff, rsp_count_in;
   logic [hdmc_pkg::KEY_W-1:0]             rsp_key_ff, rsp_key_in;
   logic [hdmc_pkg::SLOT_INDEX_W-1:0]      rsp_index_ff, rsp_index_in;

   logic                                   wr_en;
   logic [hdmc_pkg::SLOT_IDX_W-1:0]        wr_addr;
   hdmc_pkg::slot_type                     wr_slot;
   logic                                   rd_en;
   logic [hdmc_pkg::SLOT_W-1:0]            rd_data;
   hdmc_pkg::slot_type                     rd_slot;
   logic                                   out_free;
   logic                                   match;
   logic [hdmc_pkg::SLOT_IDX_W-1:0]        head_idx;
   logic [hdmc_pkg::COUNT_W-1:0]           hits_inc;

   hdmc_ram #(
      .WIDTH(hdmc_pkg::SLOT_W),
      .DEPTH(hdmc_pkg::SLOT_COUNT)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_slot),
      .rd_en   (rd_en),
      .rd_addr (head_idx),
      .rd_data (rd_data)
   );

   assign rd_slot  = hdmc_pkg::slot_type'(rd_data);
   assign head_idx = head.key[hdmc_pkg::SLOT_IDX_W-1:0];
   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   // Lookup hit test and saturating counter
   assign match    = rd_slot.valid && (rd_slot.key_hash == head.key) &&
                     (head.now < rd_slot.expiry);
   assign hits_inc = (rd_slot.hits == '1) ? rd_slot.hits : rd_slot.hits + 1'b1;

   // Sequencer: clear sweep, slot read, then execute and post the result
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_hit_in    = rsp_hit_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_index_in  = rsp_index_ff;
      pop           = 1'b0;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = head_idx;
      wr_slot       = rd_slot;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_slot = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == hdmc_pkg::SLOT_IDX_W'(hdmc_pkg::SLOT_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_status.empty) begin
               rd_en    = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               pop          = 1'b1;
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_key_in   = head.key;
               rsp_index_in = hdmc_pkg::slot_index_of(head.key);
               if (head.is_insert) begin
                  wr_en            = 1'b1;
                  wr_slot.valid    = 1'b1;
                  wr_slot.key_hash = head.key;
                  wr_slot.handle   = head.handle;
                  wr_slot.expiry   = head.expiry;
                  wr_slot.hits     = '0;
                  rsp_hit_in       = 1'b0;
                  rsp_handle_in    = '0;
                  rsp_count_in     = '0;
               end else if (match) begin
                  wr_en         = 1'b1;
                  wr_slot.hits  = hits_inc;
                  rsp_hit_in    = 1'b1;
                  rsp_handle_in = rd_slot.handle;
                  rsp_count_in  = hits_inc;
               end else begin
                  rsp_hit_in    = 1'b0;
                  rsp_handle_in = '0;
                  rsp_count_in  = rd_slot.hits;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_hit_ff    <= rsp_hit_in;
         rsp_handle_ff <= rsp_handle_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_key_ff    <= rsp_key_in;
         rsp_index_ff  <= rsp_index_in;
      end
   end

   assign clearing       = (state_ff == ST_CLEAR);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_handle_out = rsp_handle_ff;
   assign rsp_hit_count  = rsp_count_ff;
   assign rsp_key_hash   = rsp_key_ff;
   assign rsp_slot_index = rsp_index_ff;

endmodule

>>> rtl/hashed_direct_mapped_ttl_cache_top.sv
`timescale 1ns / 1ps

// Hashed direct-mapped cache with per-slot expiry and saturating hit counters.
// Request channel (req_*): one beat per name byte (action byte) folded into a
// running FNV-1a 64 hash, or one closing beat (lookup or insert) that mixes in
// record type and class and addresses slot key_hash mod SLOT_COUNT.
// Unused action codes are accepted and dropped.
// Response channel (rsp_*): one beat per lookup or insert, none for bytes.
// Throughput: name bytes go in at one per cycle while req_stall is low;
// closing beats pass one at a time through the table sequencer (a slot
// RAM read, then the execute/write-back step, held while rsp_stall is up),
// with a two-entry queue between hashing and table. With the queue empty, a
// closing beat is queued, its slot read, then its response registered.
// Reset: synchronous; afterwards the slot table is swept over all SLOT_COUNT
// slots (1024) with req_stall high, clearing valid bits and hit counters.
// A stalled response holds in its output register; the queue keeps taking
// beats until it fills, then req_stall rises.
module hashed_direct_mapped_ttl_cache_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_action,
   input  logic [hdmc_pkg::BYTE_W-1:0]        req_name_byte,
   input  logic [hdmc_pkg::RTYPE_W-1:0]       req_record_type,
   input  logic [hdmc_pkg::RCLASS_W-1:0]      req_record_class,
   input  logic [hdmc_pkg::HANDLE_W-1:0]      req_entry_handle,
   input  logic [hdmc_pkg::TIME_W-1:0]        req_expiry_time,
   input  logic [hdmc_pkg::TIME_W-1:0]        req_now_time,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_hit,
   output logic [hdmc_pkg::HANDLE_W-1:0]      rsp_handle_out,
   output logic [hdmc_pkg::COUNT_W-1:0]       rsp_hit_count,
   output logic [hdmc_pkg::KEY_W-1:0]         rsp_key_hash,
   output logic [hdmc_pkg::SLOT_INDEX_W-1:0]  rsp_slot_index
);

   logic                   push;
   logic                   pop;
   logic                   clearing;
   hdmc_pkg::job_type      push_job;
   hdmc_pkg::job_type      head;
   hdmc_pkg::q_status_type q_status;

   // Hashing and classification
   hdmc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_name_byte    (req_name_byte),
      .req_record_type  (req_record_type),
      .req_record_class (req_record_class),
      .req_entry_handle (req_entry_handle),
      .req_expiry_time  (req_expiry_time),
      .req_now_time     (req_now_time),
      .q_status         (q_status),
      .clearing         (clearing),
      .push             (push),
      .push_job         (push_job)
   );

   // Decoupling queue
   hdmc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   // Slot table sequencer
   hdmc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_status       (q_status),
      .pop            (pop),
      .clearing       (clearing),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hit        (rsp_hit),
      .rsp_handle_out (rsp_handle_out),
      .rsp_hit_count  (rsp_hit_count),
      .rsp_key_hash   (rsp_key_hash),
      .rsp_slot_index (rsp_slot_index)
   );

endmodule

>>> rtl/hdmc_checker.sv
`timescale 1ns / 1ps

module hdmc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic                               rsp_hit,
   input logic [hdmc_pkg::HANDLE_W-1:0]      rsp_handle_out,
   input logic [hdmc_pkg::COUNT_W-1:0]       rsp_hit_count,
   input logic [hdmc_pkg::KEY_W-1:0]         rsp_key_hash,
   input logic [hdmc_pkg::SLOT_INDEX_W-1:0]  rsp_slot_index
);

   // No response right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled response beat stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // Miss or insert returns no handle
   a_miss_handle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_handle_out == '0)
      else $error("handle returned without a hit");

   // A hit always leaves a nonzero counter
   a_hit_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_hit_count != '0)
      else $error("hit with zero hit count");

   // Slot index follows the key hash
   a_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_slot_index == hdmc_pkg::slot_index_of(rsp_key_hash))
      else $error("slot index does not match key hash");

endmodule

bind hashed_direct_mapped_ttl_cache_top hdmc_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_hit        (rsp_hit),
   .rsp_handle_out (rsp_handle_out),
   .rsp_hit_count  (rsp_hit_count),
   .rsp_key_hash   (rsp_key_hash),
   .rsp_slot_index (rsp_slot_index)
);

>>> tb/tb_hashed_direct_mapped_ttl_cache_top.sv
`timescale 1ns / 1ps

module tb_hashed_direct_mapped_ttl_cache_top;

   // Unused action code: accepted and dropped by the block
   localparam logic [1:0]  ACT_UNUSED      = 2'd3;
   localparam logic [63:0] NAME_HASH_BASIS = 64'd14695981039346656037;
   localparam logic [63:0] NAME_HASH_PRIME = 64'd1099511628211;
   localparam int          RTYPE_SHIFT     = 16;
   localparam int          POOL            = 24;
   localparam int          ITEM_TARGET     = 1300;

   typedef struct packed {
      logic                               hit;
      logic [hdmc_pkg::HANDLE_W-1:0]      handle;
      logic [hdmc_pkg::COUNT_W-1:0]       count;
      logic [hdmc_pkg::KEY_W-1:0]         key_hash;
      logic [hdmc_pkg::SLOT_INDEX_W-1:0]  slot_index;
   } cache_reply_type;

   // Shadow of the slot table and the name hash; predicts one reply per closing beat
   class cache_scoreboard;
      logic [hdmc_pkg::KEY_W-1:0]    fold_hash;
      bit                            slot_valid [hdmc_pkg::SLOT_COUNT];
      logic [hdmc_pkg::KEY_W-1:0]    slot_key   [hdmc_pkg::SLOT_COUNT];
      logic [hdmc_pkg::HANDLE_W-1:0] slot_handle[hdmc_pkg::SLOT_COUNT];
      logic [hdmc_pkg::TIME_W-1:0]   slot_expiry[hdmc_pkg::SLOT_COUNT];
      logic [hdmc_pkg::COUNT_W-1:0]  slot_hits  [hdmc_pkg::SLOT_COUNT];
      cache_reply_type               pending_replies[$];
      int                            errors;

      function new();
         fold_hash = NAME_HASH_BASIS;
         errors = 0;
         foreach (slot_valid[i]) begin
            slot_valid[i] = 1'b0;
            slot_key[i] = '0;
            slot_handle[i] = '0;
            slot_expiry[i] = '0;
            slot_hits[i] = '0;
         end
      endfunction

      function int pending();
         return pending_replies.size();
      endfunction

      function void note_request(logic [1:0] act, logic [7:0] nb, logic [15:0] rt,
                                 logic [15:0] rc, logic [31:0] hd, logic [31:0] ex,
                                 logic [31:0] nw);
         cache_reply_type r;
         logic [hdmc_pkg::KEY_W-1:0] key;
         int unsigned idx;
         // name byte: xor in, multiply by prime mod 2^64
         if (act == hdmc_pkg::ACT_BYTE) begin
            fold_hash = (fold_hash ^ {56'd0, nb}) * NAME_HASH_PRIME;
            return;
         end
         if (act != hdmc_pkg::ACT_LOOKUP && act != hdmc_pkg::ACT_INSERT)
            return;
         key = fold_hash ^ ({48'd0, rt} << RTYPE_SHIFT) ^ {48'd0, rc};
         idx = int'(key % 64'(hdmc_pkg::SLOT_COUNT));
         r = '0;
         r.key_hash = key;
         r.slot_index = idx[hdmc_pkg::SLOT_INDEX_W-1:0];
         if (act == hdmc_pkg::ACT_LOOKUP) begin
            if (slot_valid[idx] && slot_key[idx] == key && nw < slot_expiry[idx]) begin
               r.hit = 1'b1;
               r.handle = slot_handle[idx];
               if (slot_hits[idx] != 32'hFFFF_FFFF)
                  slot_hits[idx] = slot_hits[idx] + 1;
            end
            r.count = slot_hits[idx];
         end else begin
            slot_valid[idx] = 1'b1;
            slot_key[idx] = key;
            slot_handle[idx] = hd;
            slot_expiry[idx] = ex;
            slot_hits[idx] = '0;
         end
         fold_hash = NAME_HASH_BASIS;
         pending_replies.insert(pending_replies.size(), r);
      endfunction

      function void check_reply(logic hit, logic [31:0] handle, logic [31:0] count,
                                logic [63:0] key, logic [9:0] index);
         cache_reply_type e;
         if (pending_replies.size() == 0) begin
            $error("reply beat with no reply expected: key_hash %h", key);
            errors++;
            return;
         end
         e = pending_replies.pop_front();
         if (hit !== e.hit) begin
            $error("hit: expected %0d, got %0d", e.hit, hit);
            errors++;
         end
         if (handle !== e.handle) begin
            $error("handle_out: expected %h, got %h", e.handle, handle);
            errors++;
         end
         if (count !== e.count) begin
            $error("hit_count: expected %0d, got %0d", e.count, count);
            errors++;
         end
         if (key !== e.key_hash) begin
            $error("key_hash: expected %h, got %h", e.key_hash, key);
            errors++;
         end
         if (index !== e.slot_index) begin
            $error("slot_index: expected %0d, got %0d", e.slot_index, index);
            errors++;
         end
      endfunction
   endclass

   logic                               clock;
   logic                               reset;
   logic                               req_valid;
   logic                               req_stall;
   logic [1:0]                         req_action;
   logic [hdmc_pkg::BYTE_W-1:0]        req_name_byte;
   logic [hdmc_pkg::RTYPE_W-1:0]       req_record_type;
   logic [hdmc_pkg::RCLASS_W-1:0]      req_record_class;
   logic [hdmc_pkg::HANDLE_W-1:0]      req_entry_handle;
   logic [hdmc_pkg::TIME_W-1:0]        req_expiry_time;
   logic [hdmc_pkg::TIME_W-1:0]        req_now_time;
   logic                               rsp_valid;
   logic                               rsp_stall;
   logic                               rsp_hit;
   logic [hdmc_pkg::HANDLE_W-1:0]      rsp_handle_out;
   logic [hdmc_pkg::COUNT_W-1:0]       rsp_hit_count;
   logic [hdmc_pkg::KEY_W-1:0]         rsp_key_hash;
   logic [hdmc_pkg::SLOT_INDEX_W-1:0]  rsp_slot_index;

   cache_scoreboard sb;
   int  items_sent;
   bit  no_idle;

   hashed_direct_mapped_ttl_cache_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_name_byte    (req_name_byte),
      .req_record_type  (req_record_type),
      .req_record_class (req_record_class),
      .req_entry_handle (req_entry_handle),
      .req_expiry_time  (req_expiry_time),
      .req_now_time     (req_now_time),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_handle_out   (rsp_handle_out),
      .rsp_hit_count    (rsp_hit_count),
      .rsp_key_hash     (rsp_key_hash),
      .rsp_slot_index   (rsp_slot_index)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard limit on run time
   initial begin
      #3_000_000;
      $display("FAIL hashed_direct_mapped_ttl_cache_top");
      $finish;
   end

   // Reply side: random stall, checked at the rising edge
   always @(negedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= !no_idle && ($urandom_range(99) < 10);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_reply(rsp_hit, rsp_handle_out, rsp_hit_count, rsp_key_hash, rsp_slot_index);
   end

   // One request beat; valid stays high unless an idle gap is taken
   task automatic send_beat(input logic [1:0] act, input logic [7:0] nb,
                            input logic [15:0] rt, input logic [15:0] rc,
                            input logic [31:0] hd, input logic [31:0] ex,
                            input logic [31:0] nw);
      @(negedge clock);
      if (!no_idle && $urandom_range(99) < 10) begin
         req_valid = 1'b0;
         repeat ($urandom_range(3, 1)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_action = act;
      req_name_byte = nb;
      req_record_type = rt;
      req_record_class = rc;
      req_entry_handle = hd;
      req_expiry_time = ex;
      req_now_time = nw;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(act, nb, rt, rc, hd, ex, nw);
      if (act != ACT_UNUSED)
         items_sent++;
   endtask

   // Name bytes (first byte in the low bits), then the closing beat;
   // a noisy key carries one dropped beat somewhere before its closing beat
   task automatic send_key(input int n, input logic [63:0] name, input logic [15:0] rt,
                           input logic [15:0] rc, input logic [1:0] act,
                           input logic [31:0] hd, input logic [31:0] ex,
                           input logic [31:0] nw, input bit noisy);
      int junk_at;
      junk_at = noisy ? $urandom_range(n) : -1;
      for (int i = 0; i <= n; i++) begin
         if (i == junk_at)
            send_beat(ACT_UNUSED, 8'($urandom), 16'($urandom), 16'($urandom),
                      $urandom, $urandom, $urandom);
         if (i < n)
            send_beat(hdmc_pkg::ACT_BYTE, name[8*i +: 8], 16'($urandom), 16'($urandom),
                      $urandom, $urandom, $urandom);
      end
      send_beat(act, 8'($urandom), rt, rc, hd, ex, nw);
   endtask

   function automatic logic [31:0] pick_expiry();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 10)
         return 32'hFFFF_FFFF;
      if (sel < 20)
         return 32'($urandom_range(15));
      return $urandom;
   endfunction

   // Lookup time: mostly before expiry, some exactly at it, some after
   function automatic logic [31:0] pick_now(logic [31:0] ex);
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 60 && ex != 0)
         return $urandom_range(ex - 1, 0);
      if (sel < 75)
         return ex;
      if (sel < 90 && ex != 32'hFFFF_FFFF)
         return $urandom_range(32'hFFFF_FFFF, ex + 1);
      return $urandom;
   endfunction

   initial begin
      logic [63:0] pool_name  [POOL];
      int          pool_len   [POOL];
      logic [15:0] pool_type  [POOL];
      logic [15:0] pool_class [POOL];
      logic [31:0] pool_expiry[POOL];
      bit          pool_live  [POOL];
      int unsigned sel;
      int unsigned p;
      bit          noisy;
      logic [15:0] rt;
      logic [15:0] rc;

      sb = new();
      items_sent = 0;
      no_idle = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = hdmc_pkg::ACT_BYTE;
      req_name_byte = '0;
      req_record_type = '0;
      req_record_class = '0;
      req_entry_handle = '0;
      req_expiry_time = '0;
      req_now_time = '0;
      rsp_stall = 1'b0;
      foreach (pool_live[i])
         pool_live[i] = 1'b0;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty slot, field extremes, expiry edge, dropped code, same-slot miss
      send_key(0, 64'h0, 16'h0000, 16'h0000, hdmc_pkg::ACT_LOOKUP, 0, 0, 0, 0);
      send_key(2, 64'hFF00, 16'hFFFF, 16'hFFFF, hdmc_pkg::ACT_INSERT, 32'hFFFF_FFFF,
               32'hFFFF_FFFF, 0, 0);
      send_key(2, 64'hFF00, 16'hFFFF, 16'hFFFF, hdmc_pkg::ACT_LOOKUP, 0, 0,
               32'hFFFF_FFFE, 0);
      send_key(2, 64'hFF00, 16'hFFFF, 16'hFFFF, hdmc_pkg::ACT_LOOKUP, 0, 0,
               32'hFFFF_FFFF, 0);
      send_beat(hdmc_pkg::ACT_BYTE, 8'h00, 0, 0, 0, 0, 0);
      send_beat(ACT_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF);
      send_beat(hdmc_pkg::ACT_BYTE, 8'hFF, 0, 0, 0, 0, 0);
      send_beat(hdmc_pkg::ACT_LOOKUP, 8'h00, 16'hFFFF, 16'hFFFF, 0, 0, 0);
      send_key(0, 64'h0, 16'h0000, 16'h0000, hdmc_pkg::ACT_INSERT, 0, 0, 32'hFFFF_FFFF, 0);
      send_key(0, 64'h0, 16'h0000, 16'h0000, hdmc_pkg::ACT_LOOKUP, 0, 0, 0, 0);
      send_key(0, 64'h0, 16'h0001, 16'h0000, hdmc_pkg::ACT_LOOKUP, 0, 0, 0, 0);
      send_key(2, 64'hFF00, 16'hFFFF, 16'hFFFF, hdmc_pkg::ACT_INSERT, 32'h1234_5678, 100,
               0, 0);
      send_key(2, 64'hFF00, 16'hFFFF, 16'hFFFF, hdmc_pkg::ACT_LOOKUP, 0, 0, 99, 0);
      send_key(2, 64'hFF00, 16'hFFFF, 16'hFFFF, hdmc_pkg::ACT_LOOKUP, 0, 0, 100, 0);

      // Random: a pool of live keys that are inserted, refreshed and looked up
      while (items_sent < ITEM_TARGET) begin
         no_idle = (items_sent > 500 && items_sent < 750);
         sel = $urandom_range(99);
         p = $urandom_range(POOL - 1);
         noisy = ($urandom_range(99) < 5);
         if (sel < 20 || !pool_live[p]) begin
            pool_len[p] = $urandom_range(8);
            pool_name[p] = {$urandom, $urandom};
            pool_type[p] = 16'($urandom);
            pool_class[p] = 16'($urandom);
            pool_expiry[p] = pick_expiry();
            pool_live[p] = 1'b1;
            send_key(pool_len[p], pool_name[p], pool_type[p], pool_class[p],
                     hdmc_pkg::ACT_INSERT, $urandom, pool_expiry[p], $urandom, noisy);
         end else if (sel < 30) begin
            pool_expiry[p] = pick_expiry();
            send_key(pool_len[p], pool_name[p], pool_type[p], pool_class[p],
                     hdmc_pkg::ACT_INSERT, $urandom, pool_expiry[p], $urandom, noisy);
         end else if (sel < 80) begin
            send_key(pool_len[p], pool_name[p], pool_type[p], pool_class[p],
                     hdmc_pkg::ACT_LOOKUP, $urandom, $urandom, pick_now(pool_expiry[p]),
                     noisy);
         end else if (sel < 90) begin
            // same slot, different key: type bits or class bits above the index
            rt = pool_type[p];
            rc = pool_class[p];
            if ($urandom_range(1))
               rt = rt ^ 16'($urandom_range(16'hFFFF, 1));
            else
               rc = rc ^ (16'($urandom_range(63, 1)) << 10);
            send_key(pool_len[p], pool_name[p], rt, rc, hdmc_pkg::ACT_LOOKUP, $urandom,
                     $urandom, pick_now(pool_expiry[p]), noisy);
         end else begin
            send_key($urandom_range(8), {$urandom, $urandom}, 16'($urandom), 16'($urandom),
                     $urandom_range(1) ? hdmc_pkg::ACT_LOOKUP : hdmc_pkg::ACT_INSERT,
                     $urandom, pick_expiry(), $urandom, 1'b1);
         end
      end
      no_idle = 1'b0;

      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0)
         $display("PASS hashed_direct_mapped_ttl_cache_top");
      else
         $display("FAIL hashed_direct_mapped_ttl_cache_top");
      $finish;
   end

endmodule
